// File: src/ibl_pkg.sv
// Package for the address learning table: field widths, status and operation
// codes, the table entry type and the configuration bundle.
// No dependencies; every other file of the block depends on it.
package ibl_pkg;

   localparam int ADDR_W     = 32;
   localparam int USER_W     = 16;
   localparam int BEARER_W   = 5;
   localparam int LIMIT_W    = 6;
   localparam int STATUS_W   = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic OP_LEARN  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_HIT_VALID = 3'd3;
   localparam logic [STATUS_W-1:0] ST_HIT_BAD   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_MISS      = 3'd5;

   localparam logic REG_FIRST_DATA_BEARER = 1'b0;
   localparam logic REG_BEARER_LIMIT      = 1'b1;

   localparam logic [BEARER_W-1:0] FIRST_DATA_BEARER_RST = 5'd3;
   localparam logic [LIMIT_W-1:0]  BEARER_LIMIT_RST      = 6'd11;

   typedef struct packed {
      logic [ADDR_W-1:0]   addr;
      logic [USER_W-1:0]   user;
      logic [BEARER_W-1:0] bearer;
   } entry_type;

   typedef struct packed {
      logic [BEARER_W-1:0] first_data_bearer;
      logic [LIMIT_W-1:0]  bearer_limit;
   } cfg_type;

endpackage

// File: src/ibl_req_if.sv
// Request channel of the address learning table: valid/ready plus the
// learn or lookup payload. Depends on ibl_pkg for field widths.
interface ibl_req_if;
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [ibl_pkg::ADDR_W-1:0]   ip_address;
   logic [ibl_pkg::USER_W-1:0]   user_id;
   logic [ibl_pkg::BEARER_W-1:0] bearer_id;

   modport source (output valid, operation, ip_address, user_id, bearer_id, input ready);
   modport sink (input valid, operation, ip_address, user_id, bearer_id, output ready);
endinterface

// File: src/ibl_rsp_if.sv
// Response channel of the address learning table: valid/ready plus status
// and the matched or stored pair. Depends on ibl_pkg for field widths.
interface ibl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ibl_pkg::STATUS_W-1:0] status;
   logic [ibl_pkg::USER_W-1:0]   found_user;
   logic [ibl_pkg::BEARER_W-1:0] found_bearer;

   modport source (output valid, status, found_user, found_bearer, input ready);
   modport sink (input valid, status, found_user, found_bearer, output ready);
endinterface

// File: src/ibl_csr.sv
// APB-style configuration registers of the address learning table:
// first data bearer and bearer limit. Depends on ibl_pkg.
module ibl_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ibl_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ibl_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ibl_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output ibl_pkg::cfg_type                 cfg
);
   import ibl_pkg::*;

   logic [BEARER_W-1:0] first_data_bearer_ff, first_data_bearer_in;
   logic [LIMIT_W-1:0]  bearer_limit_ff, bearer_limit_in;
   logic                wr_en;
   logic                reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      first_data_bearer_in = first_data_bearer_ff;
      bearer_limit_in      = bearer_limit_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_FIRST_DATA_BEARER: first_data_bearer_in = csr_pwdata[BEARER_W-1:0];
            REG_BEARER_LIMIT:      bearer_limit_in      = csr_pwdata[LIMIT_W-1:0];
            default:               first_data_bearer_in = first_data_bearer_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_data_bearer_ff <= FIRST_DATA_BEARER_RST;
         bearer_limit_ff      <= BEARER_LIMIT_RST;
      end else begin
         first_data_bearer_ff <= first_data_bearer_in;
         bearer_limit_ff      <= bearer_limit_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_FIRST_DATA_BEARER:
            csr_prdata = {{(CSR_DATA_W-BEARER_W){1'b0}}, first_data_bearer_ff};
         REG_BEARER_LIMIT:
            csr_prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, bearer_limit_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   assign cfg.first_data_bearer = first_data_bearer_ff;
   assign cfg.bearer_limit      = bearer_limit_ff;

endmodule

// File: src/ip_to_bearer_learning_table_unit.sv
// Address learning table: one transaction at a time, scanned through a
// synchronous table memory, one entry read per cycle (registered read data).
// A transaction ends at the first slot whose address matches, or as a miss
// once every valid entry has been read without a match.
// The next request is taken the cycle after the response is posted; a stalled
// response holds the finished scan and the input.
// Reset clears the entry count, the FSM, the read flag and the response valid;
// table contents are not cleared, and configuration returns to first bearer 3, limit 11.
module ip_to_bearer_learning_table_unit #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   ibl_req_if.sink                          req_chan,
   ibl_rsp_if.source                        rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ibl_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ibl_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ibl_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import ibl_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] TABLE_FULL = CNT_W'(TABLE_ENTRIES);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   cfg_type cfg;

   ibl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   entry_type table_mem [TABLE_ENTRIES];
   entry_type rd_q_ff;
   logic      rd_en;
   logic      wr_en;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   entry_type wr_data;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] entry_count_ff, entry_count_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_slot_ff, rd_slot_in;

   logic                op_ff, op_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [USER_W-1:0]   user_ff, user_in;
   logic [BEARER_W-1:0] bearer_ff, bearer_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [USER_W-1:0]   rsp_user_ff, rsp_user_in;
   logic [BEARER_W-1:0] rsp_bearer_ff, rsp_bearer_in;

   logic hit;
   logic miss;
   logic out_free;
   logic bearer_ok;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign hit       = rd_valid_ff && (rd_q_ff.addr == addr_ff);
   assign miss      = !rd_valid_ff && (scan_idx_ff == entry_count_ff);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign bearer_ok = (rd_q_ff.bearer >= cfg.first_data_bearer) &&
                      ({1'b0, rd_q_ff.bearer} < cfg.bearer_limit);

   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      scan_idx_in    = scan_idx_ff;
      rd_valid_in    = rd_valid_ff;
      rd_slot_in     = rd_slot_ff;
      op_in          = op_ff;
      addr_in        = addr_ff;
      user_in        = user_ff;
      bearer_in      = bearer_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_user_in    = rsp_user_ff;
      rsp_bearer_in  = rsp_bearer_ff;
      rd_en          = 1'b0;
      rd_addr        = scan_idx_ff[IDX_W-1:0];
      wr_en          = 1'b0;
      wr_addr        = rd_slot_ff;
      wr_data        = '{addr: addr_ff, user: user_ff, bearer: bearer_ff};

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in       = req_chan.operation;
               addr_in     = req_chan.ip_address;
               user_in     = req_chan.user_id;
               bearer_in   = req_chan.bearer_id;
               scan_idx_in = '0;
               rd_valid_in = 1'b0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit || miss) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rd_valid_in  = 1'b0;
                  state_in     = S_IDLE;
                  if (op_ff == OP_LEARN) begin
                     rsp_user_in   = user_ff;
                     rsp_bearer_in = bearer_ff;
                     if (hit) begin
                        wr_en         = 1'b1;
                        wr_addr       = rd_slot_ff;
                        rsp_status_in = ST_UPDATED;
                     end else if (entry_count_ff < TABLE_FULL) begin
                        wr_en          = 1'b1;
                        wr_addr        = entry_count_ff[IDX_W-1:0];
                        entry_count_in = entry_count_ff + 1'b1;
                        rsp_status_in  = ST_ADDED;
                     end else begin
                        rsp_status_in = ST_FULL;
                        rsp_user_in   = '0;
                        rsp_bearer_in = '0;
                     end
                  end else begin
                     if (hit) begin
                        rsp_user_in   = rd_q_ff.user;
                        rsp_bearer_in = rd_q_ff.bearer;
                        rsp_status_in = bearer_ok ? ST_HIT_VALID : ST_HIT_BAD;
                     end else begin
                        rsp_status_in = ST_MISS;
                        rsp_user_in   = '0;
                        rsp_bearer_in = '0;
                     end
                  end
               end
            end else if (scan_idx_ff < entry_count_ff) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               rd_slot_in  = scan_idx_ff[IDX_W-1:0];
               scan_idx_in = scan_idx_ff + 1'b1;
            end else begin
               rd_valid_in = 1'b0;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= table_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_count_ff <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         rd_valid_ff    <= rd_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      rd_slot_ff    <= rd_slot_in;
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      user_ff       <= user_in;
      bearer_ff     <= bearer_in;
      rsp_status_ff <= rsp_status_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_bearer_ff <= rsp_bearer_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.found_user   = rsp_user_ff;
   assign rsp_chan.found_bearer = rsp_bearer_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= TABLE_FULL)
      else $error("entry count above table size");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> scan_idx_ff <= entry_count_ff)
      else $error("scan index beyond valid entries");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> state_ff == S_SCAN)
      else $error("pending table read outside a scan");

   a_count_on_add: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(entry_count_ff) |->
         entry_count_ff == $past(entry_count_ff) + 1'b1 &&
         rsp_valid_ff && rsp_status_ff == ST_ADDED)
      else $error("entry count changed without an added entry");

endmodule
